>>> hdl/wasm_branch_target_resolver_assert.svh
// assertion macros shared by the resolver rtl
`ifndef WASM_BRANCH_TARGET_RESOLVER_ASSERT_SVH
`define WASM_BRANCH_TARGET_RESOLVER_ASSERT_SVH

// same-cycle implication
`define WBTR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WBTR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/wbtr_pkg.sv
package wbtr_pkg;

  localparam int BLOCK_DEPTH   = 64;
  localparam int FIXUP_ENTRIES = 64;
  localparam int RESULT_LIMIT  = 64;

  localparam int POS_W   = 24;
  localparam int DEPTH_W = 6;
  localparam int LEVEL_W = $clog2(BLOCK_DEPTH);
  localparam int OPEN_W  = $clog2(BLOCK_DEPTH + 1);
  localparam int SLOT_W  = $clog2(FIXUP_ENTRIES);
  localparam int COUNT_W = $clog2(RESULT_LIMIT + 1);
  localparam int CMP_W   = (OPEN_W > DEPTH_W) ? OPEN_W : DEPTH_W;

  localparam int IN_DATA_W  = ((2 * POS_W + DEPTH_W + 7) / 8) * 8;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = ((2 * POS_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 3;

  typedef enum logic [2:0] {
    OP_OTHER = 3'd0,
    OP_BLOCK = 3'd1,
    OP_LOOP  = 3'd2,
    OP_IF    = 3'd3,
    OP_ELSE  = 3'd4,
    OP_BR    = 3'd5,
    OP_END   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_ELSE_NO_IF = 3'd1,
    ERR_DEPTH      = 3'd2,
    ERR_BLOCK_OVF  = 3'd3,
    ERR_FIXUP_FULL = 3'd4,
    ERR_END_EMPTY  = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    KIND_BLOCK = 2'd0,
    KIND_LOOP  = 2'd1,
    KIND_IF    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             fb_valid;
    logic [POS_W-1:0] fb_src;
    kind_t            kind;
    logic [POS_W-1:0] start;
  } block_entry_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [POS_W-1:0]   src;
  } fixup_entry_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] jump_from;
    logic [POS_W-1:0] jump_to;
    logic             last;
    err_t             err;
  } result_t;

  function automatic logic [FIXUP_ENTRIES-1:0] lowest_one(input logic [FIXUP_ENTRIES-1:0] x);
    return x & (~x + FIXUP_ENTRIES'(1));
  endfunction

  function automatic logic [SLOT_W-1:0] onehot_index(input logic [FIXUP_ENTRIES-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FIXUP_ENTRIES; i++) begin
      if (oh[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

>>> hdl/wasm_branch_target_resolver.sv
// an item is taken in ST_IDLE, the only state with s_tready high, and moves to ST_EXEC in
// the next cycle, where it waits while a result is due and the output register is full;
// it is resolved there and its result (if any) lands in the output register; an end then
// walks the fixup ram one valid slot at a time (read in ST_SCAN, compare and resolve in
// ST_CHECK), then ST_FLUSH sends any held pair; reset (rst, synchronous) clears open-block
// count, fixup valid bits, control and output valid; the stack and fixup rams are not cleared
`include "wasm_branch_target_resolver_assert.svh"

module wasm_branch_target_resolver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [wbtr_pkg::IN_DATA_W-1:0]      s_tdata,  // position, next_position, label_depth
  input  logic [wbtr_pkg::IN_USER_W-1:0]      s_tuser,  // operation, function_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wbtr_pkg::OUT_DATA_W-1:0]     m_tdata,  // jump_from, jump_to
  output logic                                m_tlast,
  output logic [wbtr_pkg::OUT_USER_W-1:0]     m_tuser   // error
);
  import wbtr_pkg::*;

  localparam int BLK_W = $bits(block_entry_t);
  localparam int FIX_W = $bits(fixup_entry_t);

  state_t state, state_next;
  logic   accept;
  logic   out_free;
  result_t res;

  // item registers
  op_t                op_q;
  logic               fs_q;
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   nxt_q;
  logic [DEPTH_W-1:0] depth_q;

  logic [OPEN_W-1:0]        open_blocks, open_blocks_next;
  logic [FIXUP_ENTRIES-1:0] fixup_valid, fixup_valid_next;

  // end walk registers
  logic [LEVEL_W-1:0]       pop_level, pop_level_next;
  logic [POS_W-1:0]         target, target_next;
  logic [FIXUP_ENTRIES-1:0] scan_mask, scan_mask_next;
  logic [SLOT_W-1:0]        sel_slot, sel_slot_next;
  logic                     held_valid, held_valid_next;
  logic [POS_W-1:0]         held_src, held_src_next;
  logic [COUNT_W-1:0]       count, count_next;
  logic                     dropped, dropped_next;

  // ram ports
  logic               blk_we, blk_re;
  logic [LEVEL_W-1:0] blk_waddr, blk_raddr;
  block_entry_t       blk_wdata;
  logic [BLK_W-1:0]   blk_rd;
  logic               fix_we, fix_re;
  logic [SLOT_W-1:0]  fix_waddr, fix_raddr;
  fixup_entry_t       fix_wdata;
  logic [FIX_W-1:0]   fix_rd;

  block_entry_t             top_ent;
  fixup_entry_t             fe;
  logic [LEVEL_W-1:0]       top;
  logic [FIXUP_ENTRIES-1:0] free_oh, scan_oh;
  logic                     have_free;
  logic [SLOT_W-1:0]        free_slot;
  err_t                     err;
  logic                     emit;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // the implicit function block is written the same cycle it is read: forward it
  always_comb begin
    if (fs_q) begin
      top_ent          = '0;
      top_ent.kind     = KIND_BLOCK;
    end else begin
      top_ent = block_entry_t'(blk_rd);
    end
  end

  assign fe        = fixup_entry_t'(fix_rd);
  assign top       = LEVEL_W'(open_blocks - OPEN_W'(1));
  assign free_oh   = lowest_one(~fixup_valid);
  assign have_free = |(~fixup_valid);
  assign free_slot = onehot_index(free_oh);
  assign scan_oh   = lowest_one(scan_mask);

  always_comb begin
    err = ERR_NONE;
    case (op_q)
      OP_BLOCK, OP_LOOP, OP_IF: begin
        if (open_blocks == OPEN_W'(BLOCK_DEPTH)) err = ERR_BLOCK_OVF;
      end
      OP_ELSE: begin
        if (open_blocks == '0 || top_ent.kind != KIND_IF || !top_ent.fb_valid) begin
          err = ERR_ELSE_NO_IF;
        end else if (!have_free) begin
          err = ERR_FIXUP_FULL;
        end
      end
      OP_BR: begin
        if (CMP_W'(depth_q) >= CMP_W'(open_blocks)) begin
          err = ERR_DEPTH;
        end else if (!have_free) begin
          err = ERR_FIXUP_FULL;
        end
      end
      OP_END: begin
        if (open_blocks == '0) err = ERR_END_EMPTY;
      end
      default: ;
    endcase
  end

  assign emit = (err != ERR_NONE) || (op_q == OP_ELSE);

  always_comb begin
    state_next       = state;
    res              = '0;
    open_blocks_next = open_blocks;
    fixup_valid_next = fixup_valid;
    pop_level_next   = pop_level;
    target_next      = target;
    scan_mask_next   = scan_mask;
    sel_slot_next    = sel_slot;
    held_valid_next  = held_valid;
    held_src_next    = held_src;
    count_next       = count;
    dropped_next     = dropped;
    blk_we           = 1'b0;
    blk_waddr        = '0;
    blk_wdata        = '0;
    blk_re           = 1'b0;
    blk_raddr        = '0;
    fix_we           = 1'b0;
    fix_waddr        = free_slot;
    fix_wdata        = '0;
    fix_re           = 1'b0;
    fix_raddr        = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          blk_re = 1'b1;
          if (s_tuser[3]) begin
            fixup_valid_next = '0;
            open_blocks_next = OPEN_W'(1);
            blk_we           = 1'b1;
            blk_waddr        = '0;
            blk_wdata.kind   = KIND_BLOCK;
            blk_raddr        = '0;
          end else begin
            blk_raddr = top;
          end
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (!(emit && !out_free)) begin
          state_next = ST_IDLE;
          if (err != ERR_NONE) begin
            res.valid = 1'b1;
            res.last  = 1'b1;
            res.err   = err;
          end else begin
            case (op_q)
              OP_BLOCK, OP_LOOP, OP_IF: begin
                blk_we             = 1'b1;
                blk_waddr          = LEVEL_W'(open_blocks);
                blk_wdata.fb_valid = (op_q == OP_IF);
                blk_wdata.fb_src   = nxt_q;
                blk_wdata.kind     = (op_q == OP_BLOCK) ? KIND_BLOCK :
                                     (op_q == OP_LOOP)  ? KIND_LOOP  : KIND_IF;
                blk_wdata.start    = pos_q;
                open_blocks_next   = open_blocks + OPEN_W'(1);
              end
              OP_ELSE: begin
                res.valid          = 1'b1;
                res.jump_from      = top_ent.fb_src;
                res.jump_to        = nxt_q;
                res.last           = 1'b1;
                blk_we             = 1'b1;
                blk_waddr          = top;
                blk_wdata          = top_ent;
                blk_wdata.fb_valid = 1'b0;
                fix_we             = 1'b1;
                fix_wdata.level    = top;
                fix_wdata.src      = nxt_q;
                fixup_valid_next[free_slot] = 1'b1;
              end
              OP_BR: begin
                fix_we          = 1'b1;
                fix_wdata.level = LEVEL_W'(open_blocks - OPEN_W'(1) - OPEN_W'(depth_q));
                fix_wdata.src   = nxt_q;
                fixup_valid_next[free_slot] = 1'b1;
              end
              OP_END: begin
                pop_level_next   = top;
                target_next      = (top_ent.kind == KIND_LOOP) ? top_ent.start : pos_q;
                held_valid_next  = top_ent.fb_valid;
                held_src_next    = top_ent.fb_src;
                count_next       = top_ent.fb_valid ? COUNT_W'(1) : '0;
                dropped_next     = 1'b0;
                scan_mask_next   = fixup_valid;
                open_blocks_next = open_blocks - OPEN_W'(1);
                state_next       = ST_SCAN;
              end
              default: ;
            endcase
          end
        end
      end

      ST_SCAN: begin
        if (scan_mask == '0) begin
          state_next = ST_FLUSH;
        end else begin
          fix_re         = 1'b1;
          fix_raddr      = onehot_index(scan_oh);
          sel_slot_next  = onehot_index(scan_oh);
          scan_mask_next = scan_mask & ~scan_oh;
          state_next     = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (fe.level != pop_level) begin
          state_next = ST_SCAN;
        end else if (count == COUNT_W'(RESULT_LIMIT)) begin
          dropped_next               = 1'b1;
          fixup_valid_next[sel_slot] = 1'b0;
          state_next                 = ST_SCAN;
        end else if (!(held_valid && !out_free)) begin
          // the held pair goes out only once a later one shows it is not the last
          if (held_valid) begin
            res.valid     = 1'b1;
            res.jump_from = held_src;
            res.jump_to   = target;
          end
          held_valid_next            = 1'b1;
          held_src_next              = fe.src;
          count_next                 = count + COUNT_W'(1);
          fixup_valid_next[sel_slot] = 1'b0;
          state_next                 = ST_SCAN;
        end
      end

      ST_FLUSH: begin
        if (!held_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          res.valid       = 1'b1;
          res.jump_from   = held_src;
          res.jump_to     = target;
          res.last        = 1'b1;
          res.err         = dropped ? ERR_FIXUP_FULL : ERR_NONE;
          held_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      open_blocks <= '0;
      fixup_valid <= '0;
      held_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      open_blocks <= open_blocks_next;
      fixup_valid <= fixup_valid_next;
      held_valid  <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(s_tuser[2:0]);
      fs_q    <= s_tuser[3];
      pos_q   <= s_tdata[POS_W-1:0];
      nxt_q   <= s_tdata[2*POS_W-1:POS_W];
      depth_q <= s_tdata[2*POS_W+DEPTH_W-1:2*POS_W];
    end
    pop_level <= pop_level_next;
    target    <= target_next;
    scan_mask <= scan_mask_next;
    sel_slot  <= sel_slot_next;
    held_src  <= held_src_next;
    count     <= count_next;
    dropped   <= dropped_next;
  end

  wbtr_ram #(.WIDTH(BLK_W), .DEPTH(BLOCK_DEPTH)) u_block_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .re    (blk_re),
    .raddr (blk_raddr),
    .rdata (blk_rd)
  );

  wbtr_ram #(.WIDTH(FIX_W), .DEPTH(FIXUP_ENTRIES)) u_fixup_ram (
    .clk   (clk),
    .we    (fix_we),
    .waddr (fix_waddr),
    .wdata (fix_wdata),
    .re    (fix_re),
    .raddr (fix_raddr),
    .rdata (fix_rd)
  );

  wbtr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  `WBTR_ASSERT_IMP(a_open_bound, clk, rst, 1'b1, open_blocks <= OPEN_W'(BLOCK_DEPTH), "open block count past stack depth")
  `WBTR_ASSERT_IMP(a_push_free, clk, rst, res.valid, out_free, "item pushed into a full output register")
  `WBTR_ASSERT_IMP(a_count_bound, clk, rst, state == ST_CHECK || state == ST_FLUSH, count <= COUNT_W'(RESULT_LIMIT), "resolved pair count past limit")
  `WBTR_ASSERT_IMP(a_drop_held, clk, rst, dropped && (state == ST_CHECK || state == ST_FLUSH), held_valid, "dropped fixup without a held pair")
  `WBTR_ASSERT_NXT(a_accept_exec, clk, rst, accept, state == ST_EXEC, "accepted item not executed next cycle")

endmodule

>>> hdl/wbtr_ram.sv
module wbtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hdl/wbtr_out_reg.sv
module wbtr_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  wbtr_pkg::result_t                   push,
  output logic                                free,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wbtr_pkg::OUT_DATA_W-1:0]     m_tdata,  // jump_from, jump_to
  output logic                                m_tlast,
  output logic [wbtr_pkg::OUT_USER_W-1:0]     m_tuser   // error
);
  import wbtr_pkg::*;

  logic [POS_W-1:0] jump_from;
  logic [POS_W-1:0] jump_to;
  logic             last;
  err_t             err;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      jump_from <= push.jump_from;
      jump_to   <= push.jump_to;
      last      <= push.last;
      err       <= push.err;
    end
  end

  assign m_tdata = OUT_DATA_W'({jump_to, jump_from});
  assign m_tlast = last;
  assign m_tuser = OUT_USER_W'(err);

endmodule

>>> bench/wasm_branch_target_resolver_test.sv
`timescale 1ns / 1ps

module wasm_branch_target_resolver_test;
  import wbtr_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 80;
  localparam int CALM_TAIL = 25;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [2:0]         op;
    logic               fstart;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   nxt;
    logic [DEPTH_W-1:0] depth;
  } instr_t;

  typedef struct packed {
    logic [POS_W-1:0] jump_from;
    logic [POS_W-1:0] jump_to;
    logic             last;
    err_t             err;
  } pair_t;

  typedef struct packed {
    logic [2:0]         op;
    logic               fstart;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   nxt;
    logic [DEPTH_W-1:0] depth;
    logic               typed;
    err_t               err;
  } row_t;

  // directed rows; typed rows carry their single error result
  localparam row_t DIRECTED [25] = '{
    '{OP_END,    1'b0, 24'h000000, 24'h000000, 6'd0,  1'b1, ERR_END_EMPTY},
    '{OP_ELSE,   1'b0, 24'hFFFFFF, 24'hFFFFFF, 6'd0,  1'b1, ERR_ELSE_NO_IF},
    '{OP_BR,     1'b0, 24'h000000, 24'h000000, 6'd0,  1'b1, ERR_DEPTH},
    '{OP_OTHER,  1'b0, 24'h123456, 24'h654321, 6'd63, 1'b0, ERR_NONE},
    '{OP_UNUSED, 1'b0, 24'hABCDEF, 24'hFEDCBA, 6'd21, 1'b0, ERR_NONE},
    '{OP_OTHER,  1'b1, 24'h000000, 24'h000001, 6'd0,  1'b0, ERR_NONE},
    '{OP_IF,     1'b0, 24'h000010, 24'h000012, 6'd0,  1'b0, ERR_NONE},
    '{OP_BR,     1'b0, 24'h000014, 24'hFFFFFF, 6'd1,  1'b0, ERR_NONE},
    '{OP_BR,     1'b0, 24'h000018, 24'h000020, 6'd0,  1'b0, ERR_NONE},
    '{OP_ELSE,   1'b0, 24'h000030, 24'h000031, 6'd0,  1'b0, ERR_NONE},
    '{OP_ELSE,   1'b0, 24'h000032, 24'h000033, 6'd0,  1'b1, ERR_ELSE_NO_IF},
    '{OP_END,    1'b0, 24'h000040, 24'h000041, 6'd0,  1'b0, ERR_NONE},
    '{OP_LOOP,   1'b0, 24'hFFFFFF, 24'h000000, 6'd0,  1'b0, ERR_NONE},
    '{OP_BR,     1'b0, 24'h000050, 24'h000055, 6'd0,  1'b0, ERR_NONE},
    '{OP_BR,     1'b0, 24'h000056, 24'h000058, 6'd63, 1'b1, ERR_DEPTH},
    '{OP_END,    1'b0, 24'h000000, 24'h000001, 6'd0,  1'b0, ERR_NONE},
    '{OP_BLOCK,  1'b0, 24'h000060, 24'h000061, 6'd0,  1'b0, ERR_NONE},
    '{OP_ELSE,   1'b0, 24'h000062, 24'h000063, 6'd0,  1'b1, ERR_ELSE_NO_IF},
    '{OP_END,    1'b0, 24'h000064, 24'h000065, 6'd0,  1'b0, ERR_NONE},
    '{OP_IF,     1'b0, 24'h000070, 24'h000072, 6'd0,  1'b0, ERR_NONE},
    '{OP_END,    1'b0, 24'h000080, 24'h000081, 6'd0,  1'b0, ERR_NONE},
    '{OP_END,    1'b0, 24'h000090, 24'h000091, 6'd0,  1'b0, ERR_NONE},
    '{OP_END,    1'b0, 24'h0000A0, 24'h0000A1, 6'd0,  1'b1, ERR_END_EMPTY},
    '{OP_BR,     1'b1, 24'h0000B0, 24'hAAAAAA, 6'd0,  1'b0, ERR_NONE},
    '{OP_END,    1'b1, 24'h555555, 24'h000000, 6'd0,  1'b0, ERR_NONE}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // position, next_position, label_depth
  logic [IN_USER_W-1:0]  s_tuser = '0;   // operation, function_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // jump_from, jump_to
  logic                  m_tlast;
  logic [OUT_USER_W-1:0] m_tuser;        // error

  wasm_branch_target_resolver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // predictor state: open frame stack and pending branch patches
  logic [POS_W-1:0] frame_start    [BLOCK_DEPTH];
  kind_t            frame_kind     [BLOCK_DEPTH];
  logic             frame_fb_valid [BLOCK_DEPTH];
  logic [POS_W-1:0] frame_fb_src   [BLOCK_DEPTH];
  int               open_frames = 0;
  logic [POS_W-1:0] patch_src      [FIXUP_ENTRIES];
  int               patch_level    [FIXUP_ENTRIES];
  logic             patch_busy     [FIXUP_ENTRIES];

  pair_t step_pairs[$];
  pair_t expected_pairs[$];
  pair_t want_pair;
  pair_t seen_pair;
  int    mismatches = 0;
  bit    idle_on = 1'b1;
  int    cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int free_patch_slot();
    for (int i = 0; i < FIXUP_ENTRIES; i++) begin
      if (!patch_busy[i]) return i;
    end
    return -1;
  endfunction

  function automatic void open_frame(kind_t kind, logic [POS_W-1:0] start, logic fb_valid,
                                     logic [POS_W-1:0] fb_src);
    frame_start[open_frames]    = start;
    frame_kind[open_frames]     = kind;
    frame_fb_valid[open_frames] = fb_valid;
    frame_fb_src[open_frames]   = fb_src;
    open_frames++;
  endfunction

  function automatic void flag_error(err_t code);
    pair_t p;
    p = '{'0, '0, 1'b1, code};
    step_pairs.delete();
    step_pairs.insert(step_pairs.size(), p);
  endfunction

  // computes the jump pairs resolved by one instruction into step_pairs
  function automatic void resolve_instr(instr_t it);
    int               slot;
    int               top;
    logic [POS_W-1:0] target;
    bit               dropped;
    pair_t            p;
    step_pairs.delete();
    dropped = 1'b0;
    if (it.fstart) begin
      for (int i = 0; i < FIXUP_ENTRIES; i++) patch_busy[i] = 1'b0;
      open_frames = 0;
      open_frame(KIND_BLOCK, '0, 1'b0, '0);
    end
    top = open_frames - 1;
    case (it.op)
      OP_BLOCK, OP_LOOP, OP_IF: begin
        if (open_frames >= BLOCK_DEPTH) begin
          flag_error(ERR_BLOCK_OVF);
          return;
        end
        if (it.op == OP_BLOCK) open_frame(KIND_BLOCK, it.pos, 1'b0, '0);
        else if (it.op == OP_LOOP) open_frame(KIND_LOOP, it.pos, 1'b0, '0);
        else open_frame(KIND_IF, it.pos, 1'b1, it.nxt);
      end
      OP_ELSE: begin
        if (open_frames == 0) begin
          flag_error(ERR_ELSE_NO_IF);
          return;
        end
        if (frame_kind[top] != KIND_IF || !frame_fb_valid[top]) begin
          flag_error(ERR_ELSE_NO_IF);
          return;
        end
        slot = free_patch_slot();
        if (slot < 0) begin
          flag_error(ERR_FIXUP_FULL);
          return;
        end
        p = '{frame_fb_src[top], it.nxt, 1'b0, ERR_NONE};
        step_pairs.insert(step_pairs.size(), p);
        frame_fb_valid[top] = 1'b0;
        patch_src[slot]     = it.nxt;
        patch_level[slot]   = top;
        patch_busy[slot]    = 1'b1;
      end
      OP_BR: begin
        if (int'(it.depth) >= open_frames) begin
          flag_error(ERR_DEPTH);
          return;
        end
        slot = free_patch_slot();
        if (slot < 0) begin
          flag_error(ERR_FIXUP_FULL);
          return;
        end
        patch_src[slot]   = it.nxt;
        patch_level[slot] = top - int'(it.depth);
        patch_busy[slot]  = 1'b1;
      end
      OP_END: begin
        if (open_frames == 0) begin
          flag_error(ERR_END_EMPTY);
          return;
        end
        // a loop label points back to its start, everything else to the end
        target = (frame_kind[top] == KIND_LOOP) ? frame_start[top] : it.pos;
        if (frame_fb_valid[top]) begin
          p = '{frame_fb_src[top], target, 1'b0, ERR_NONE};
          step_pairs.insert(step_pairs.size(), p);
        end
        frame_fb_valid[top] = 1'b0;
        for (int i = 0; i < FIXUP_ENTRIES; i++) begin
          if (patch_busy[i] && patch_level[i] == top) begin
            if (step_pairs.size() < RESULT_LIMIT) begin
              p = '{patch_src[i], target, 1'b0, ERR_NONE};
              step_pairs.insert(step_pairs.size(), p);
            end else begin
              dropped = 1'b1;
            end
            patch_busy[i] = 1'b0;
          end
        end
        open_frames--;
        if (dropped && step_pairs.size() > 0)
          step_pairs[step_pairs.size() - 1].err = ERR_FIXUP_FULL;
      end
      default: begin
      end
    endcase
    if (step_pairs.size() > 0) step_pairs[step_pairs.size() - 1].last = 1'b1;
  endfunction

  function automatic instr_t make_instr(logic [2:0] op, logic fstart, logic [DEPTH_W-1:0] depth);
    instr_t it;
    it.op     = op;
    it.fstart = fstart;
    it.pos    = POS_W'($urandom);
    it.nxt    = POS_W'($urandom);
    it.depth  = depth;
    return it;
  endfunction

  // drives one item, waits for the handshake and books what it should produce
  task automatic send_instr(instr_t it, bit typed, err_t typed_err);
    pair_t p;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({it.depth, it.nxt, it.pos});
    s_tuser  <= {it.fstart, it.op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    resolve_instr(it);
    if (typed) begin
      p = '{'0, '0, 1'b1, typed_err};
      expected_pairs.insert(expected_pairs.size(), p);
    end else begin
      foreach (step_pairs[i]) expected_pairs.insert(expected_pairs.size(), step_pairs[i]);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_pair = '{m_tdata[POS_W-1:0], m_tdata[2*POS_W-1:POS_W], m_tlast, err_t'(m_tuser)};
      if (expected_pairs.size() == 0) begin
        $error("result with nothing expected: from %h to %h last %0d error %0d",
               seen_pair.jump_from, seen_pair.jump_to, seen_pair.last, seen_pair.err);
        mismatches++;
      end else begin
        want_pair = expected_pairs.pop_front();
        if (seen_pair.jump_from !== want_pair.jump_from) begin
          $error("jump_from: expected %h, got %h", want_pair.jump_from, seen_pair.jump_from);
          mismatches++;
        end
        if (seen_pair.jump_to !== want_pair.jump_to) begin
          $error("jump_to: expected %h, got %h", want_pair.jump_to, seen_pair.jump_to);
          mismatches++;
        end
        if (seen_pair.last !== want_pair.last) begin
          $error("last: expected %0d, got %0d", want_pair.last, seen_pair.last);
          mismatches++;
        end
        if (seen_pair.err !== want_pair.err) begin
          $error("error: expected %0d, got %0d", want_pair.err, seen_pair.err);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("wasm_branch_target_resolver: mismatch");
    $finish;
  end

  initial begin
    instr_t it;
    int     counted;
    int     issued;
    int     r;
    int     top;
    for (int i = 0; i < FIXUP_ENTRIES; i++) patch_busy[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      it = '{DIRECTED[i].op, DIRECTED[i].fstart, DIRECTED[i].pos, DIRECTED[i].nxt,
             DIRECTED[i].depth};
      send_instr(it, DIRECTED[i].typed, DIRECTED[i].err);
    end

    // hold off until the resolver has drained
    s_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);

    // fill the frame stack and the patch store to the brim
    send_instr(make_instr(OP_OTHER, 1'b1, '0), 1'b0, ERR_NONE);
    repeat (BLOCK_DEPTH - 2) send_instr(make_instr(OP_BLOCK, 1'b0, '0), 1'b0, ERR_NONE);
    send_instr(make_instr(OP_IF, 1'b0, '0), 1'b0, ERR_NONE);
    send_instr(make_instr(OP_LOOP, 1'b0, '0), 1'b0, ERR_NONE);
    repeat (FIXUP_ENTRIES) send_instr(make_instr(OP_BR, 1'b0, '0), 1'b0, ERR_NONE);
    send_instr(make_instr(OP_BR, 1'b0, DEPTH_W'($urandom)), 1'b0, ERR_NONE);
    send_instr(make_instr(OP_ELSE, 1'b0, '0), 1'b0, ERR_NONE);
    // if false branch plus a full store is one pair too many
    send_instr(make_instr(OP_END, 1'b0, '0), 1'b0, ERR_NONE);
    // a fresh function drops the rest of the stack, its end leaves nothing open
    send_instr(make_instr(OP_END, 1'b1, '0), 1'b0, ERR_NONE);

    counted = 0;
    issued = 0;
    while (counted < RANDOM_ITEMS) begin
      if (issued % 25 == 0)
        idle_on = (counted < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      top = open_frames - 1;
      it = make_instr(OP_OTHER, 1'b0, '0);
      if (open_frames == 0) begin
        if (r < 85) begin
          it.fstart = 1'b1;
          it.op = $urandom_range(0, 1) ? OP_OTHER : OP_BLOCK;
        end else begin
          it.op = 3'($urandom_range(0, 7));
          it.depth = DEPTH_W'($urandom);
        end
      end else if (r < 8) begin
        // noise: any code, any depth, now and then a fresh function
        it.op = 3'($urandom_range(0, 7));
        it.fstart = ($urandom_range(0, 7) == 0);
        it.depth = DEPTH_W'($urandom);
      end else if (r < 35 && open_frames < 12) begin
        it.op = 3'($urandom_range(OP_BLOCK, OP_IF));
      end else if (r < 45 && frame_kind[top] == KIND_IF && frame_fb_valid[top]) begin
        it.op = OP_ELSE;
      end else if (r < 72) begin
        it.op = OP_BR;
        it.depth = DEPTH_W'($urandom_range(0, top));
      end else begin
        it.op = OP_END;
      end
      send_instr(it, 1'b0, ERR_NONE);
      issued++;
      if (it.op != OP_OTHER && it.op != OP_UNUSED) counted++;
    end

    s_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("wasm_branch_target_resolver: match");
    end else begin
      $display("wasm_branch_target_resolver: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/wbtr_pkg.sv
hdl/wbtr_ram.sv
hdl/wbtr_out_reg.sv
hdl/wasm_branch_target_resolver.sv
bench/wasm_branch_target_resolver_test.sv
